// File: hdl/svs_pkg.sv
package svs_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 64;
  localparam int POS_W    = 6;
  localparam int ECNT_W   = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } res_code_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_SRCH_CMP,
    S_CHK_CMP,
    S_MOVE_RD,
    S_MOVE_WR,
    S_INS_WR,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic clr;
    logic srch_rd;
    logic srch_upd;
    logic chk_rd;
    logic ptr_ins;
    logic ptr_rem;
    logic mv_rd;
    logic mv_wr;
    logic ins_wr;
    logic cnt_inc;
    logic cnt_dec;
    logic set_nf;
    logic set_full;
    logic resp_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic lo_lt_hi;
    logic lo_lt_cnt;
    logic hit;
    logic ins_move;
    logic rem_move;
    logic move_more;
    logic out_free;
  } dp_stat_t;

endpackage

// File: hdl/svs_ram.sv
module svs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/svs_ctrl.sv
module svs_ctrl import svs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic [1:0] op,
  output logic     in_ready,
  input  dp_stat_t st,
  output dp_cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load = 1'b1;
          case (op_t'(op))
            OP_CLEAR: begin
              cmd.clr    = 1'b1;
              state_next = S_RESP;
            end
            OP_INSERT: begin
              if (st.full) begin
                cmd.set_full = 1'b1;
                state_next   = S_RESP;
              end else begin
                state_next = S_SEARCH;
              end
            end
            default: state_next = S_SEARCH;
          endcase
        end
      end
      S_SEARCH: begin
        if (st.lo_lt_hi) begin
          cmd.srch_rd = 1'b1;
          state_next  = S_SRCH_CMP;
        end else if (st.op == OP_INSERT) begin
          if (st.ins_move) begin
            cmd.ptr_ins = 1'b1;
            state_next  = S_MOVE_RD;
          end else begin
            state_next = S_INS_WR;
          end
        end else if (st.lo_lt_cnt) begin
          cmd.chk_rd = 1'b1;
          state_next = S_CHK_CMP;
        end else begin
          cmd.set_nf = 1'b1;
          state_next = S_RESP;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_upd = 1'b1;
        state_next   = S_SEARCH;
      end
      S_CHK_CMP: begin
        if (!st.hit) begin
          cmd.set_nf = 1'b1;
          state_next = S_RESP;
        end else if (st.op == OP_REMOVE && st.rem_move) begin
          cmd.ptr_rem = 1'b1;
          state_next  = S_MOVE_RD;
        end else begin
          cmd.cnt_dec = (st.op == OP_REMOVE);
          state_next  = S_RESP;
        end
      end
      S_MOVE_RD: begin
        cmd.mv_rd  = 1'b1;
        state_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        cmd.mv_wr = 1'b1;
        if (st.move_more) begin
          state_next = S_MOVE_RD;
        end else if (st.op == OP_INSERT) begin
          state_next = S_INS_WR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = S_RESP;
        end
      end
      S_INS_WR: begin
        cmd.ins_wr  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (st.out_free) begin
          cmd.resp_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: hdl/svs_dp.sv
module svs_dp import svs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [1:0]               op,
  input  logic signed [VAL_W-1:0]  value,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 st,
  input  logic                     out_ready,
  output logic                     out_valid,
  output logic [1:0]               status,
  output logic [POS_W-1:0]         position,
  output logic [ECNT_W-1:0]        entry_count
);

  op_t                    op_r;
  logic signed [VAL_W-1:0] value_r;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       lo;
  logic [CNT_W-1:0]       hi;
  logic [CNT_W-1:0]       ptr;
  res_code_t              res_status;

  logic [CNT_W-1:0]       mid;
  logic [CNT_W-1:0]       ptr_dn;
  logic [CNT_W-1:0]       ptr_up;
  logic                   go_right;

  logic                   ram_we;
  logic [IDX_W-1:0]       ram_waddr;
  logic [VAL_W-1:0]       ram_wdata;
  logic [IDX_W-1:0]       ram_raddr;
  logic [VAL_W-1:0]       ram_rdata;

  svs_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mid    = lo + ((hi - lo) >> 1);
  assign ptr_dn = ptr - 1'b1;
  assign ptr_up = ptr + 1'b1;

  // insert lands after equal entries, remove/find look for the first equal one
  assign go_right = (op_r == OP_INSERT) ? ($signed(ram_rdata) <= value_r)
                                        : ($signed(ram_rdata) <  value_r);

  always_comb begin
    ram_raddr = '0;
    if (cmd.srch_rd) begin
      ram_raddr = mid[IDX_W-1:0];
    end else if (cmd.chk_rd) begin
      ram_raddr = lo[IDX_W-1:0];
    end else if (cmd.mv_rd) begin
      ram_raddr = (op_r == OP_INSERT) ? ptr_dn[IDX_W-1:0] : ptr_up[IDX_W-1:0];
    end
  end

  assign ram_we    = cmd.mv_wr | cmd.ins_wr;
  assign ram_waddr = cmd.mv_wr ? ptr[IDX_W-1:0] : lo[IDX_W-1:0];
  assign ram_wdata = cmd.mv_wr ? ram_rdata : value_r;

  always_comb begin
    st.op        = op_r;
    st.full      = (count == CNT_W'(CAPACITY));
    st.lo_lt_hi  = (lo < hi);
    st.lo_lt_cnt = (lo < count);
    st.hit       = (ram_rdata == value_r);
    st.ins_move  = (count > lo);
    st.rem_move  = (({1'b0, lo} + 1'b1) < {1'b0, count});
    st.move_more = (op_r == OP_INSERT) ? (ptr_dn > lo)
                                       : (({1'b0, ptr} + 2'd2) < {1'b0, count});
    st.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= op_t'(op);
      value_r    <= value;
      lo         <= '0;
      hi         <= count;
      if (cmd.set_full) begin
        res_status <= ST_FULL;
      end else begin
        res_status <= ST_OK;
      end
    end else if (cmd.set_nf) begin
      res_status <= ST_NOT_FOUND;
    end
    if (cmd.srch_upd) begin
      if (go_right) begin
        lo <= mid + 1'b1;
      end else begin
        hi <= mid;
      end
    end
    if (cmd.ptr_ins) begin
      ptr <= count;
    end else if (cmd.ptr_rem) begin
      ptr <= lo;
    end else if (cmd.mv_wr) begin
      ptr <= (op_r == OP_INSERT) ? ptr_dn : ptr_up;
    end
    if (cmd.resp_load) begin
      status      <= res_status;
      position    <= (res_status == ST_OK) ? POS_W'(lo) : '0;
      entry_count <= ECNT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) begin
        count <= '0;
      end else if (cmd.cnt_inc) begin
        count <= count + 1'b1;
      end else if (cmd.cnt_dec) begin
        count <= count - 1'b1;
      end
      if (cmd.resp_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/sorted_value_set_core.sv
// Channel   Handshake             Payload
// -------   -------------------   -------------------------------------------
// in        in_valid / in_ready   op[1:0], value[63:0] (signed)
// out       out_valid / out_ready status[1:0], position[5:0], entry_count[6:0]
//
// One transaction at a time. Clear or insert-when-full: accept, then
// respond. Otherwise each binary-search probe is a registered read, then a
// compare, about log2(count)+1 probes, plus the accept, the final bound check,
// the insert write or equality check, and the response. Each entry shifted
// by insert or remove adds a registered read, then a write.
// Reset (rst, synchronous) empties the list at once; entry contents are kept
// but never read past the count. A new transaction is taken while a result
// still waits on out; the next result holds until the output register frees.
module sorted_value_set_core import svs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              op,
  input  logic signed [VAL_W-1:0] value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              status,
  output logic [POS_W-1:0]        position,
  output logic [ECNT_W-1:0]       entry_count
);

  dp_cmd_t  cmd;
  dp_stat_t st;

  // sequence search, check and shift steps
  svs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .op       (op),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // hold the list, search bounds, shift pointer and result register
  svs_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .value       (value),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .status      (status),
    .position    (position),
    .entry_count (entry_count)
  );

endmodule

// File: hdl/svs_checker.sv
module svs_checker import svs_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [1:0]          status,
  input logic [POS_W-1:0]    position,
  input logic [ECNT_W-1:0]   entry_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(position)
      && $stable(entry_count))
    else $error("result changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == ECNT_W'(CAPACITY))
    else $error("full reported below capacity");

  a_nf_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOT_FOUND || status == ST_FULL) |-> position == '0)
    else $error("failure with nonzero position");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= ECNT_W'(CAPACITY))
    else $error("count above capacity");

  a_rst_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_value_set_core svs_checker u_svs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .position    (position),
  .entry_count (entry_count)
);

// File: tb/sv/svs_checker.sv
module svs_predictor
  import svs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic [1:0]              op,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [1:0]              status,
  input  logic [POS_W-1:0]        position,
  input  logic [ECNT_W-1:0]       entry_count,
  output int                      fail_count,
  output int                      results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    res_code_t             st;
    logic [POS_W-1:0]      pos;
    logic [ECNT_W-1:0]     cnt;
  } set_outcome_t;

  logic signed [VAL_W-1:0] sorted_vals[CAPACITY];
  int                      sorted_size;
  set_outcome_t            awaited_outcomes[$];
  set_outcome_t            head;

  // Apply one operation to the shadow list and return the outcome it yields.
  function automatic set_outcome_t apply_set_op(op_t o, logic signed [VAL_W-1:0] v);
    set_outcome_t res;
    int           i;
    res.st  = ST_OK;
    res.pos = '0;
    i       = 0;
    case (o)
      OP_INSERT: begin
        if (sorted_size >= CAPACITY) begin
          res.st = ST_FULL;
        end else begin
          // land after any equal entries
          while (i < sorted_size && sorted_vals[i] <= v) i++;
          for (int j = sorted_size; j > i; j--) sorted_vals[j] = sorted_vals[j-1];
          sorted_vals[i] = v;
          sorted_size++;
          res.pos = POS_W'(i);
        end
      end
      OP_REMOVE, OP_FIND: begin
        while (i < sorted_size && sorted_vals[i] < v) i++;
        if (i < sorted_size && sorted_vals[i] == v) begin
          res.pos = POS_W'(i);
          if (o == OP_REMOVE) begin
            for (int j = i; j < sorted_size - 1; j++) sorted_vals[j] = sorted_vals[j+1];
            sorted_size--;
          end
        end else begin
          res.st = ST_NOT_FOUND;
        end
      end
      default: begin
        sorted_size = 0;
      end
    endcase
    res.cnt = ECNT_W'(sorted_size);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      sorted_size = 0;
      awaited_outcomes.delete();
    end else begin
      // a result leaving now belongs to an earlier transaction: check first
      if (out_valid && out_ready) begin
        if (awaited_outcomes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result status=%0d position=%0d entry_count=%0d",
                   $time, status, position, entry_count);
        end else begin
          head = awaited_outcomes.pop_front();
          if (status !== head.st) begin
            fail_count++;
            $display("%0t: status expected %0d, got %0d", $time, head.st, status);
          end
          if (position !== head.pos) begin
            fail_count++;
            $display("%0t: position expected %0d, got %0d", $time, head.pos, position);
          end
          if (entry_count !== head.cnt) begin
            fail_count++;
            $display("%0t: entry_count expected %0d, got %0d", $time, head.cnt, entry_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_outcomes.push_back(apply_set_op(op_t'(op), value));
      end
    end
    results_due = awaited_outcomes.size();
  end

endmodule

// File: tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import svs_pkg::*;

  // The whole run of 1175 transactions, each at worst length with its sender
  // gap, stays far below this bound.
  localparam int CYCLE_LIMIT  = 1_000_000;
  // Longest single transaction plus margin; covers the tail after the last result.
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES  = 500;
  localparam int HOLD_AT      = 300;
  localparam int PHASE_ITEMS  = 115;
  localparam int NUM_PHASES   = 10;
  localparam int POOL_DEPTH   = 32;

  localparam logic signed [VAL_W-1:0] MAX_VAL = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] MIN_VAL = 64'sh8000_0000_0000_0000;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic [1:0]              op;
  logic signed [VAL_W-1:0] value;
  logic                    out_valid;
  logic                    out_ready;
  logic [1:0]              status;
  logic [POS_W-1:0]        position;
  logic [ECNT_W-1:0]       entry_count;
  int                      fail_count;
  int                      results_due;

  // Percent of insert transactions per phase; the heavy phases push the list
  // to capacity so the full case shows up repeatedly.
  int insert_weight[NUM_PHASES] = '{50, 85, 30, 85, 50, 40, 90, 30, 60, 85};

  // Recently inserted values, reused so that finds and removes actually hit.
  logic signed [VAL_W-1:0] inserted_pool[$];

  int results_taken;
  int cycle_count;

  sorted_value_set_core DUT (.*);

  svs_predictor u_checker (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hold valid and payload from the falling edge until the rising edge that
  // takes the transaction, then hold valid low for the drawn gap, if any.
  task automatic send_item(input op_t o, input logic signed [VAL_W-1:0] v, input int gap);
    @(negedge clk);
    in_valid <= 1'b1;
    op       <= o;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    if (o == OP_INSERT) begin
      inserted_pool.push_back(v);
      if (inserted_pool.size() > POOL_DEPTH) void'(inserted_pool.pop_front());
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Mix pool hits, a narrow band around zero, corner values and full-range noise.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30 && inserted_pool.size() > 0)
      return inserted_pool[$urandom_range(0, inserted_pool.size() - 1)];
    if (r < 55)
      return $signed(64'($urandom_range(0, 16))) - 64'sd8;
    if (r < 65) begin
      case ($urandom_range(0, 5))
        0:       return MAX_VAL;
        1:       return MIN_VAL;
        2:       return 64'sd0;
        3:       return -64'sd1;
        4:       return MIN_VAL + 64'sd1;
        default: return MAX_VAL - 64'sd1;
      endcase
    end
    return {$urandom, $urandom};
  endfunction

  // Stimulus: reset, a directed pass over the corners, then phased random traffic.
  initial begin
    int                      r;
    int                      gap;
    op_t                     o;
    logic signed [VAL_W-1:0] v;

    rst      = 1'b1;
    in_valid = 1'b0;
    op       = OP_INSERT;
    value    = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list: lookups and removes must miss
    send_item(OP_FIND,   64'sd0, $urandom_range(0, 3));
    send_item(OP_REMOVE, 64'sd5, $urandom_range(0, 3));
    // extremes, zero, neighbors and duplicates at both ends and the middle
    send_item(OP_INSERT, MAX_VAL, $urandom_range(0, 3));
    send_item(OP_INSERT, MIN_VAL, $urandom_range(0, 3));
    send_item(OP_INSERT, 64'sd0,  $urandom_range(0, 3));
    send_item(OP_INSERT, -64'sd1, $urandom_range(0, 3));
    send_item(OP_INSERT, 64'sd1,  $urandom_range(0, 3));
    send_item(OP_INSERT, 64'sd0,  $urandom_range(0, 3));
    send_item(OP_INSERT, MAX_VAL, $urandom_range(0, 3));
    send_item(OP_INSERT, MIN_VAL, $urandom_range(0, 3));
    // find reports the lowest index among duplicates and misses absent values
    send_item(OP_FIND,   MIN_VAL, $urandom_range(0, 3));
    send_item(OP_FIND,   MAX_VAL, $urandom_range(0, 3));
    send_item(OP_FIND,   64'sd0,  $urandom_range(0, 3));
    send_item(OP_FIND,   64'sd2,  $urandom_range(0, 3));
    send_item(OP_FIND,   -64'sd2, $urandom_range(0, 3));
    // remove the lowest duplicate, the ends, and an absent value
    send_item(OP_REMOVE, 64'sd0,  $urandom_range(0, 3));
    send_item(OP_REMOVE, MIN_VAL, $urandom_range(0, 3));
    send_item(OP_REMOVE, MAX_VAL, $urandom_range(0, 3));
    send_item(OP_REMOVE, 64'sd7,  $urandom_range(0, 3));
    // alternating bit patterns, one positive and one negative
    send_item(OP_INSERT, 64'sh5555_5555_5555_5555, $urandom_range(0, 3));
    send_item(OP_INSERT, 64'shAAAA_AAAA_AAAA_AAAA, $urandom_range(0, 3));
    send_item(OP_FIND,   64'shAAAA_AAAA_AAAA_AAAA, $urandom_range(0, 3));
    // clear, then confirm nothing is left
    send_item(OP_CLEAR,  64'sd0,  $urandom_range(0, 3));
    send_item(OP_FIND,   64'sd1,  $urandom_range(0, 3));
    send_item(OP_REMOVE, -64'sd1, $urandom_range(0, 3));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r == 0)
          o = OP_CLEAR;
        else if (r <= insert_weight[ph])
          o = OP_INSERT;
        else if (r[0])
          o = OP_REMOVE;
        else
          o = OP_FIND;
        v = pick_value();
        // every third phase runs back to back with no sender gaps
        gap = (ph % 3 == 1) ? 0 : $urandom_range(0, 3);
        send_item(o, v, gap);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (results_due == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Result side: random stalls per transaction, gap-free stretches, and one
  // long hold-off so the core fills up and drops in_ready.
  initial begin
    int  stall;
    int  hold;
    bit  held;
    out_ready     = 1'b0;
    results_taken = 0;
    held          = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && results_taken >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        hold = 0;
        while (hold < HOLD_CYCLES) begin
          @(negedge clk);
          hold++;
        end
      end
      stall = ((results_taken / 200) % 2 == 0) ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      results_taken++;
      @(negedge clk);
    end
  end

  // Watchdog: end the run as failed if it has not finished by the time limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

endmodule
